>>> src/bcd_pkg.sv
// Shared types and constants for the button click and drag detector.
`default_nettype none

package bcd_pkg;

   localparam int TIME_BITS  = 32;
   localparam int COUNT_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 15;
   localparam int WINDOW_BITS    = 8;

   typedef logic [TIME_BITS-1:0]         time_type;
   typedef logic signed [COUNT_BITS-1:0] count_type;
   typedef logic [WINDOW_BITS-1:0]       window_type;
   typedef logic [CSR_DATA_BITS-1:0]     csr_data_type;
   typedef logic [1:0]                   fill_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CLICK_WINDOW        = 2'd0,
      CSR_DOUBLE_CLICK_WINDOW = 2'd1,
      CSR_DRAG_THRESHOLD      = 2'd2
   } csr_index_type;

   localparam window_type   CLICK_WINDOW_RESET        = window_type'(5);
   localparam window_type   DOUBLE_CLICK_WINDOW_RESET = window_type'(10);
   localparam csr_data_type DRAG_THRESHOLD_RESET      = csr_data_type'(5);

   localparam count_type COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam count_type COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
   localparam count_type COUNT_ONE = count_type'(1);
   localparam count_type COUNT_NEG_ONE = '1;

   localparam fill_type FILL_FULL = fill_type'(2);

   typedef struct packed {
      count_type hold_count;
      logic      clicked;
      logic      double_clicked;
      logic      dragged;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/bcd_req_if.sv
// Input channel: one sampled button level and frame time per item.
`default_nettype none

interface bcd_req_if;
   logic              valid;
   logic              ready;
   logic              pressed;
   bcd_pkg::time_type frame_time;

   modport source (output valid, output pressed, output frame_time, input ready);
   modport sink   (input valid, input pressed, input frame_time, output ready);
endinterface

`default_nettype wire

>>> src/bcd_rsp_if.sv
// Result channel: hold count and click, double-click and drag flags.
`default_nettype none

interface bcd_rsp_if;
   logic               valid;
   logic               ready;
   bcd_pkg::count_type hold_count;
   logic               clicked;
   logic               double_clicked;
   logic               dragged;

   modport source (output valid, output hold_count, output clicked,
                   output double_clicked, output dragged, input ready);
   modport sink   (input valid, input hold_count, input clicked,
                   input double_clicked, input dragged, output ready);
endinterface

`default_nettype wire

>>> src/bcd_csr_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface bcd_csr_if;
   logic                   valid;
   logic                   ready;
   bcd_pkg::csr_index_type index;
   bcd_pkg::csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/button_click_drag_detector.sv
// Top level of the button click, double-click and drag detector.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-------------------------------------------
//   req_port | in  | valid/ready  | pressed, frame_time
//   rsp_port | out | valid/ready  | hold_count, clicked, double_clicked, dragged
//   csr_port | in  | valid/ready  | index, data
//
// One item per cycle while req ready is high; its result is registered.
// The state update and flag compares sit between the input handshake and a
// result register backed by a one-entry skid register, so req ready is a
// register and stays high while one result waits. A stall of two results
// drops req ready. Synchronous reset clears the hold counter, press log fill
// and configuration to their defaults; csr ready is always high.
`default_nettype none

module button_click_drag_detector (
   input  wire                   clock,
   input  wire                   reset,
   bcd_req_if.sink               req_port,
   bcd_rsp_if.source             rsp_port,
   bcd_csr_if.sink               csr_port
);

   bcd_pkg::window_type   click_window_ff;
   bcd_pkg::window_type   double_click_window_ff;
   bcd_pkg::csr_data_type drag_threshold_ff;

   bcd_pkg::count_type hold_count_ff, hold_count_in;
   bcd_pkg::time_type  press_time0_ff, press_time1_ff;
   bcd_pkg::fill_type  fill_ff, fill_in;

   bcd_pkg::rsp_type out_ff, skid_ff, result_in;
   logic             out_valid_ff, skid_valid_ff;

   logic              accept;
   logic              drain;
   logic              log_press;
   bcd_pkg::time_type age0, age1;
   logic              near0, near1;

   assign accept = req_port.valid && req_port.ready;
   assign drain  = rsp_port.valid && rsp_port.ready;
   assign req_port.ready = !skid_valid_ff;
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         click_window_ff        <= bcd_pkg::CLICK_WINDOW_RESET;
         double_click_window_ff <= bcd_pkg::DOUBLE_CLICK_WINDOW_RESET;
         drag_threshold_ff      <= bcd_pkg::DRAG_THRESHOLD_RESET;
      end else if (csr_port.valid) begin
         case (csr_port.index)
            bcd_pkg::CSR_CLICK_WINDOW: begin
               click_window_ff <= csr_port.data[bcd_pkg::WINDOW_BITS-1:0];
            end
            bcd_pkg::CSR_DOUBLE_CLICK_WINDOW: begin
               double_click_window_ff <= csr_port.data[bcd_pkg::WINDOW_BITS-1:0];
            end
            bcd_pkg::CSR_DRAG_THRESHOLD: begin
               drag_threshold_ff <= csr_port.data;
            end
            default: begin
            end
         endcase
      end
   end

   // Counter step: restart on an edge, otherwise saturate toward its sign.
   always_comb begin
      hold_count_in = hold_count_ff;
      fill_in       = fill_ff;
      log_press     = 1'b0;
      if (req_port.pressed) begin
         if (hold_count_ff < 0) begin
            hold_count_in = bcd_pkg::COUNT_ONE;
            log_press     = 1'b1;
            if (fill_ff != bcd_pkg::FILL_FULL) begin
               fill_in = fill_ff + 2'd1;
            end
         end else if (hold_count_ff != bcd_pkg::COUNT_MAX) begin
            hold_count_in = hold_count_ff + bcd_pkg::COUNT_ONE;
         end
      end else begin
         if (hold_count_ff > 0) begin
            hold_count_in = bcd_pkg::COUNT_NEG_ONE;
         end else if (hold_count_ff != bcd_pkg::COUNT_MIN) begin
            hold_count_in = hold_count_ff - bcd_pkg::COUNT_ONE;
         end
      end
   end

   // A count of -1 never comes with a new press, so the stored times apply.
   assign age0  = req_port.frame_time - press_time0_ff;
   assign age1  = req_port.frame_time - press_time1_ff;
   assign near0 = age0 <= bcd_pkg::time_type'(click_window_ff);
   assign near1 = age1 <= bcd_pkg::time_type'(double_click_window_ff);

   always_comb begin
      result_in.hold_count     = hold_count_in;
      result_in.clicked        = (hold_count_in == bcd_pkg::COUNT_NEG_ONE) &&
                                 (fill_ff != 2'd0) && near0;
      result_in.double_clicked = (hold_count_in == bcd_pkg::COUNT_NEG_ONE) &&
                                 (fill_ff == bcd_pkg::FILL_FULL) && near0 && near1;
      result_in.dragged        = hold_count_in >
                                 $signed({1'b0, drag_threshold_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff <= '0;
         fill_ff       <= '0;
      end else if (accept) begin
         hold_count_ff <= hold_count_in;
         fill_ff       <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && log_press) begin
         press_time1_ff <= press_time0_ff;
         press_time0_ff <= req_port.frame_time;
      end
   end

   // Result register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (drain) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!out_valid_ff || drain) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (drain) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (drain) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || drain) begin
            out_ff <= result_in;
         end else begin
            skid_ff <= result_in;
         end
      end
   end

   assign rsp_port.valid          = out_valid_ff;
   assign rsp_port.hold_count     = out_ff.hold_count;
   assign rsp_port.clicked        = out_ff.clicked;
   assign rsp_port.double_clicked = out_ff.double_clicked;
   assign rsp_port.dragged        = out_ff.dragged;

endmodule

`default_nettype wire
